/* hdl/scf_pkg.sv */
// Shared types, status codes, register indexes and reset values for the
// sum checked frame receiver. No dependencies.
`timescale 1ns / 1ps

package scf_pkg;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_STORED   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_HDR_ERR  = 3'd3;
    localparam logic [2:0] ST_OK       = 3'd4;
    localparam logic [2:0] ST_SUM_ERR  = 3'd5;
    localparam logic [2:0] ST_TIMEOUT  = 3'd6;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [1:0] CFG_HDR_LEN = 2'd0;
    localparam logic [1:0] CFG_HDR_VAL = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [2:0]  HDR_LEN_MAX   = 3'd4;
    localparam logic [2:0]  RST_HDR_LEN   = 3'd1;
    localparam logic [31:0] RST_HDR_VAL   = 32'h0000_00FA;
    localparam logic [15:0] RST_LIMIT     = 16'd256;
    localparam logic [15:0] RST_TIMEOUT   = 16'd20;
    localparam logic [15:0] IDLE_SAT      = 16'hFFFF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] byte_position;
        logic [7:0]  byte_value;
        logic [15:0] frame_length;
    } t_result;

endpackage

/* hdl/scf_in_if.sv */
// Input channel of the frame receiver: valid/ready handshake carrying one word.
// No dependencies.
`timescale 1ns / 1ps

interface scf_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source(output valid, output req_type, output rx_byte, input ready);
    modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

/* hdl/scf_out_if.sv */
// Result channel of the frame receiver: valid/ready handshake carrying one word.
// No dependencies.
`timescale 1ns / 1ps

interface scf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] byte_position;
    logic [7:0]  byte_value;
    logic [15:0] frame_length;

    modport source(output valid, output status, output byte_position,
                   output byte_value, output frame_length, input ready);
    modport sink(input valid, input status, input byte_position,
                 input byte_value, input frame_length, output ready);
endinterface

/* hdl/sum_checked_frame_receiver.sv */
// A word accepted into the input register has its result formed by the core step logic and held in the result register.
// Throughput: one word per cycle while the result channel does not stall; the frame state updates once per word.
// Stalls on the result channel back up through the input register to the input ready.
// Reset is synchronous and active low: both stages empty, the frame state clears,
// and the configuration registers return to their default values.
`timescale 1ns / 1ps

module sum_checked_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    scf_in_if.sink      i_in,
    scf_out_if.source   o_out
);

    scf_pkg::t_item   in_item;
    scf_pkg::t_item   stage_item;
    scf_pkg::t_result core_res;
    scf_pkg::t_result out_res;
    logic             stage_valid;
    logic             out_ready;
    logic             fire;

    assign in_item.req_type = i_in.req_type;
    assign in_item.rx_byte  = i_in.rx_byte;
    assign fire             = stage_valid && out_ready;

    scf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (i_in.ready),
        .i_take  (out_ready),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    scf_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (stage_item),
        .o_res      (core_res)
    );

    scf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_res   (core_res),
        .o_ready (out_ready),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.status        = out_res.status;
    assign o_out.byte_position = out_res.byte_position;
    assign o_out.byte_value    = out_res.byte_value;
    assign o_out.frame_length  = out_res.frame_length;

endmodule

/* hdl/scf_in_reg.sv */
// Input register stage: captures one word and holds it until the core takes it.
// Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  scf_pkg::t_item i_item,
    output logic          o_ready,
    input  logic          i_take,
    output logic          o_valid,
    output scf_pkg::t_item o_item
);

    logic           r_valid;
    scf_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/scf_core.sv */
// Frame state, configuration registers and the per-word step logic.
// Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_fire,
    input  scf_pkg::t_item  i_item,
    output scf_pkg::t_result o_res
);

    logic [2:0]  r_hdr_len;
    logic [31:0] r_hdr_val;
    logic [15:0] r_limit;
    logic [15:0] r_timeout;

    logic [15:0] r_count,   n_count;
    logic        r_hdr_acc, n_hdr_acc;
    logic        r_mism,    n_mism;
    logic [15:0] r_len,     n_len;
    logic [7:0]  r_sum,     n_sum;
    logic [7:0]  r_prev,    n_prev;
    logic [15:0] r_idle,    n_idle;

    logic [2:0]  hl;
    logic [7:0]  hdr_byte;
    logic [15:0] cnt;
    logic        mism;
    logic        acc;
    logic        clear;
    logic        hdr_err;
    logic [15:0] len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len <= scf_pkg::RST_HDR_LEN;
            r_hdr_val <= scf_pkg::RST_HDR_VAL;
            r_limit   <= scf_pkg::RST_LIMIT;
            r_timeout <= scf_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scf_pkg::CFG_HDR_LEN: r_hdr_len <= i_cfg_data[2:0];
                scf_pkg::CFG_HDR_VAL: r_hdr_val <= i_cfg_data;
                scf_pkg::CFG_LIMIT:   r_limit   <= i_cfg_data[15:0];
                scf_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign hl       = (r_hdr_len > scf_pkg::HDR_LEN_MAX) ? scf_pkg::HDR_LEN_MAX : r_hdr_len;
    assign hdr_byte = 8'(r_hdr_val >> {r_count[1:0], 3'b000});

    always_comb begin
        n_count   = r_count;
        n_hdr_acc = r_hdr_acc;
        n_mism    = r_mism;
        n_len     = r_len;
        n_sum     = r_sum;
        n_prev    = r_prev;
        n_idle    = r_idle;
        o_res     = '0;
        clear     = 1'b0;
        hdr_err   = 1'b0;
        cnt       = r_count + 16'd1;
        mism      = r_mism;
        acc       = r_hdr_acc;
        len       = r_len;

        if (i_item.req_type == scf_pkg::REQ_TICK) begin
            o_res.status = scf_pkg::ST_NONE;
            if (r_count != 16'd0) begin
                n_idle = (r_idle != scf_pkg::IDLE_SAT) ? r_idle + 16'd1 : r_idle;
                o_res.frame_length = r_len;
                if (n_idle >= r_timeout) begin
                    clear = 1'b1;
                    if (r_hdr_acc) begin
                        o_res.status = scf_pkg::ST_TIMEOUT;
                    end
                end
            end
        end else begin
            n_idle              = 16'd0;
            o_res.byte_position = r_count;
            o_res.byte_value    = i_item.rx_byte;
            if ({1'b0, r_count} + 17'd1 >= {1'b0, r_limit}) begin
                clear        = 1'b1;
                o_res.status = scf_pkg::ST_OVERFLOW;
            end else begin
                if (r_count < {13'd0, hl} && i_item.rx_byte != hdr_byte) begin
                    mism = 1'b1;
                end
                n_mism  = mism;
                n_sum   = r_sum + i_item.rx_byte;
                n_count = cnt;
                n_prev  = i_item.rx_byte;
                if (!r_hdr_acc && {1'b0, cnt} >= {14'd0, hl} + 17'd2) begin
                    if (mism) begin
                        hdr_err = 1'b1;
                    end else begin
                        len = {r_prev, i_item.rx_byte};
                        acc = 1'b1;
                    end
                end
                if (hdr_err) begin
                    clear        = 1'b1;
                    o_res.status = scf_pkg::ST_HDR_ERR;
                end else begin
                    n_len              = len;
                    n_hdr_acc          = acc;
                    o_res.frame_length = len;
                    if (acc && {2'b00, cnt} >= {2'b00, len} + {15'd0, hl} + 18'd2) begin
                        clear        = 1'b1;
                        o_res.status = (r_sum == i_item.rx_byte) ? scf_pkg::ST_OK
                                                                 : scf_pkg::ST_SUM_ERR;
                    end else begin
                        o_res.status = scf_pkg::ST_STORED;
                    end
                end
            end
        end

        if (clear) begin
            n_count   = 16'd0;
            n_hdr_acc = 1'b0;
            n_mism    = 1'b0;
            n_len     = 16'd0;
            n_sum     = 8'd0;
            n_idle    = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 16'd0;
            r_hdr_acc <= 1'b0;
            r_mism    <= 1'b0;
            r_len     <= 16'd0;
            r_sum     <= 8'd0;
            r_prev    <= 8'd0;
            r_idle    <= 16'd0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_hdr_acc <= n_hdr_acc;
            r_mism    <= n_mism;
            r_len     <= n_len;
            r_sum     <= n_sum;
            r_prev    <= n_prev;
            r_idle    <= n_idle;
        end
    end

    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_acc |-> r_count >= 16'd2)
        else $error("header accepted with fewer than two bytes counted");

    a_len_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hdr_acc |-> r_len == 16'd0)
        else $error("length held without an accepted header");

    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 16'd0 |-> r_idle == 16'd0 && r_sum == 8'd0)
        else $error("empty frame with nonzero idle count or sum");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_res.status == scf_pkg::ST_OK || o_res.status == scf_pkg::ST_SUM_ERR)
        |=> r_count == 16'd0 && !r_hdr_acc)
        else $error("frame not cleared after completion");

endmodule

/* hdl/scf_out_reg.sv */
// Result register: holds one result word until the downstream side takes it.
// Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  scf_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output scf_pkg::t_result o_res
);

    logic             r_valid;
    scf_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* tb/sv/tb_sum_checked_frame_receiver.sv */
// Testbench for the sum checked frame receiver: sends bytes and ticks, predicts each
// result word from its own frame model and compares field by field.
// Depends on scf_pkg, scf_in_if, scf_out_if and sum_checked_frame_receiver.
`timescale 1ns / 1ps

module tb_sum_checked_frame_receiver;
    import scf_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int MAX_PRINTS  = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    scf_in_if  rx_ch();
    scf_out_if res_ch();

    sum_checked_frame_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (rx_ch),
        .o_out      (res_ch)
    );

    logic [2:0]  cfg_hdr_len;
    logic [31:0] cfg_hdr_val;
    logic [15:0] cfg_limit;
    logic [15:0] cfg_timeout;

    logic [15:0] fr_count;
    logic        fr_hdr_ok;
    logic        fr_hdr_bad;
    logic [15:0] fr_len;
    logic [7:0]  fr_sum;
    logic [7:0]  fr_prev;
    logic [15:0] fr_idle;

    t_result expected_words[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left = 0;
    int      stall_cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int header_bytes();
        return (cfg_hdr_len > HDR_LEN_MAX) ? int'(HDR_LEN_MAX) : int'(cfg_hdr_len);
    endfunction

    function automatic void clear_frame();
        fr_count   = '0;
        fr_hdr_ok  = 1'b0;
        fr_hdr_bad = 1'b0;
        fr_len     = '0;
        fr_sum     = '0;
        fr_idle    = '0;
    endfunction

    function automatic void reset_receiver_model();
        cfg_hdr_len = RST_HDR_LEN;
        cfg_hdr_val = RST_HDR_VAL;
        cfg_limit   = RST_LIMIT;
        cfg_timeout = RST_TIMEOUT;
        clear_frame();
        fr_prev = '0;
    endfunction

    function automatic t_result frame_step(input t_item w);
        t_result     r;
        int unsigned hl;
        int unsigned pos;
        int unsigned cnt;
        logic [7:0]  b;
        logic [7:0]  sum_before;
        logic        acc;
        hl = header_bytes();
        r = '0;
        if (w.req_type == REQ_TICK) begin
            if (fr_count != 0) begin
                if (fr_idle != IDLE_SAT) fr_idle++;
                if (fr_idle >= cfg_timeout) begin
                    acc = fr_hdr_ok;
                    r.status = acc ? ST_TIMEOUT : ST_NONE;
                    r.frame_length = acc ? fr_len : '0;
                    clear_frame();
                end else begin
                    r.status = ST_NONE;
                    r.frame_length = fr_hdr_ok ? fr_len : '0;
                end
            end
            return r;
        end
        b = w.rx_byte;
        pos = 32'(fr_count);
        fr_idle = '0;
        r.byte_position = pos[15:0];
        r.byte_value = b;
        if (pos + 1 >= cfg_limit) begin
            clear_frame();
            r.status = ST_OVERFLOW;
            return r;
        end
        if (pos < hl && b != cfg_hdr_val[8*pos +: 8]) fr_hdr_bad = 1'b1;
        sum_before = fr_sum;
        fr_sum = fr_sum + b;
        cnt = pos + 1;
        fr_count = cnt[15:0];
        if (!fr_hdr_ok && cnt >= hl + 2) begin
            if (fr_hdr_bad) begin
                clear_frame();
                fr_prev = b;
                r.status = ST_HDR_ERR;
                return r;
            end
            fr_len = {fr_prev, b};
            fr_hdr_ok = 1'b1;
        end
        fr_prev = b;
        if (fr_hdr_ok && cnt >= fr_len + hl + 2) begin
            r.frame_length = fr_len;
            r.status = (sum_before == b) ? ST_OK : ST_SUM_ERR;
            clear_frame();
            return r;
        end
        r.status = ST_STORED;
        r.frame_length = fr_hdr_ok ? fr_len : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing expected", 32'(res_ch.status), '0);
            end else begin
                want = expected_words.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", 32'(res_ch.status), 32'(want.status));
                if (res_ch.byte_position !== want.byte_position)
                    report_mismatch("byte_position", 32'(res_ch.byte_position),
                                    32'(want.byte_position));
                if (res_ch.byte_value !== want.byte_value)
                    report_mismatch("byte_value", 32'(res_ch.byte_value),
                                    32'(want.byte_value));
                if (res_ch.frame_length !== want.frame_length)
                    report_mismatch("frame_length", 32'(res_ch.frame_length),
                                    32'(want.frame_length));
            end
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else begin
                res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(input logic kind, input logic [7:0] value);
        t_item w;
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid = 1'b0;
            @(negedge clk);
        end
        w.req_type = kind;
        w.rx_byte = value;
        rx_ch.valid = 1'b1;
        rx_ch.req_type = kind;
        rx_ch.rx_byte = value;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1) @(posedge clk);
        expected_words.push_back(frame_step(w));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        rx_ch.valid = 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_HDR_LEN: cfg_hdr_len = value[2:0];
            CFG_HDR_VAL: cfg_hdr_val = value;
            CFG_LIMIT:   cfg_limit = value[15:0];
            CFG_TIMEOUT: cfg_timeout = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int hl, input logic [31:0] hv, input int lim,
                                 input int tmo);
        wait_drain();
        write_reg(CFG_HDR_LEN, hl);
        write_reg(CFG_HDR_VAL, hv);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // A negative cut sends the whole frame; otherwise only the first cut bytes go out.
    task automatic send_frame(input int len_field, input bit hdr_good, input bit sum_good,
                              input int cut);
        logic [7:0] bytes[$];
        logic [7:0] sum;
        int         hl;
        int         n;
        hl = header_bytes();
        for (int i = 0; i < hl; i++) bytes.push_back(cfg_hdr_val[8*i +: 8]);
        if (!hdr_good && hl > 0)
            bytes[$urandom_range(hl - 1)] ^= 8'($urandom_range(1, 255));
        bytes.push_back(len_field[15:8]);
        bytes.push_back(len_field[7:0]);
        for (int i = 1; i < len_field; i++) bytes.push_back(8'($urandom));
        if (len_field > 0) begin
            sum = '0;
            foreach (bytes[i]) sum = sum + bytes[i];
            bytes.push_back(sum_good ? sum : sum ^ 8'($urandom_range(1, 255)));
        end
        n = (cut >= 0 && cut < bytes.size()) ? cut : bytes.size();
        for (int i = 0; i < n; i++) begin
            send_word(REQ_BYTE, bytes[i]);
            if (cfg_timeout > 1 && $urandom_range(99) < 5) send_word(REQ_TICK, 8'($urandom));
        end
    endtask

    task automatic flush_frame();
        int n;
        n = 0;
        while (fr_count != 0 && n < 70) begin
            send_word(REQ_TICK, 8'($urandom));
            n++;
        end
    endtask

    task automatic test_default_frame();
        send_word(REQ_TICK, 8'hFF);
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h02);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'hF9);
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h02);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h00);
    endtask

    task automatic test_header_error();
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h12);
        send_word(REQ_BYTE, 8'h34);
    endtask

    task automatic test_zero_length();
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h00);
    endtask

    task automatic test_timeout();
        load_settings(1, RST_HDR_VAL, int'(RST_LIMIT), 2);
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h05);
        send_word(REQ_TICK, 8'h00);
        send_word(REQ_TICK, 8'hFF);
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_TICK, 8'h00);
        send_word(REQ_TICK, 8'h00);
    endtask

    task automatic test_overflow();
        load_settings(1, RST_HDR_VAL, 4, int'(RST_TIMEOUT));
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h05);
        send_word(REQ_BYTE, 8'hAA);
    endtask

    task automatic test_odd_registers();
        // No header bytes at all, then a zero length frame that checks out.
        load_settings(0, 32'h0, int'(RST_LIMIT), int'(RST_TIMEOUT));
        send_frame(2, 1'b1, 1'b1, -1);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h00);
        // Header lengths above the maximum act as the maximum; a zero timeout clears at once.
        load_settings(7, 32'h1122_3344, int'(RST_LIMIT), 0);
        send_frame(1, 1'b1, 1'b1, -1);
        send_word(REQ_BYTE, 8'h44);
        send_word(REQ_TICK, 8'h00);
        load_settings(1, RST_HDR_VAL, 1, int'(RST_TIMEOUT));
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h01);
        load_settings(1, RST_HDR_VAL, 0, int'(RST_TIMEOUT));
        send_word(REQ_BYTE, 8'h80);
        // The header length changes while a frame is half received.
        load_settings(1, RST_HDR_VAL, int'(RST_LIMIT), int'(RST_TIMEOUT));
        send_word(REQ_BYTE, 8'hFA);
        send_word(REQ_BYTE, 8'h00);
        wait_drain();
        write_reg(CFG_HDR_LEN, 3);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h03);
        send_word(REQ_BYTE, 8'h01);
        flush_frame();
    endtask

    task automatic test_random_traffic(input int hl, input logic [31:0] hv, input int lim,
                                       input int tmo, input int n_words);
        int stop_at;
        int pick;
        int len;
        int max_len;
        int ehl;
        load_settings(hl, hv, lim, tmo);
        ehl = header_bytes();
        max_len = lim - ehl - 3;
        stop_at = items_sent + n_words;
        while (items_sent < stop_at) begin
            flush_frame();
            len = $urandom_range(1, 12);
            if ($urandom_range(99) < 10) len = $urandom_range(0, 40);
            if (max_len >= 0 && len > max_len) len = max_len;
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_frame(len, 1'b1, $urandom_range(99) < 85, -1);
            end else if (pick < 75) begin
                send_frame(len, 1'b0, 1'b1, -1);
            end else if (pick < 85) begin
                send_frame(len, 1'b1, 1'b1, $urandom_range(1, ehl + 3));
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 4)) send_word(1'($urandom_range(1)), 8'($urandom));
            end else begin
                send_frame(300, 1'b1, 1'b1, (lim < 80) ? lim + 1 : 20);
            end
        end
    endtask

    task automatic test_backpressure();
        load_settings(2, 32'($urandom), 1000, 50);
        hold_left = 90;
        send_frame(12, 1'b1, 1'b1, -1);
        send_frame(12, 1'b1, 1'b0, -1);
        send_frame(12, 1'b1, 1'b1, -1);
        wait_drain();
        send_frame(5, 1'b1, 1'b1, -1);
    endtask

    initial begin
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_HDR_LEN;
        cfg_data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.req_type = REQ_BYTE;
        rx_ch.rx_byte = '0;
        reset_receiver_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(22, 71);
        test_default_frame();
        test_header_error();
        test_zero_length();
        test_timeout();
        test_overflow();
        test_odd_registers();
        test_random_traffic(1, RST_HDR_VAL, int'(RST_LIMIT), int'(RST_TIMEOUT), 70);
        test_random_traffic(4, 32'hFFFF_FFFF, 65535, 1, 70);
        test_random_traffic(2, 32'($urandom), 40, 8, 70);

        set_idling(71, 22);
        test_random_traffic(3, 32'h0, 4, 65535, 70);
        test_random_traffic(4, 32'($urandom), 100, 30, 70);
        test_random_traffic(1, 32'($urandom), 16, 3, 70);

        set_idling(0, 0);
        test_backpressure();
        test_random_traffic(2, 32'($urandom), 65535, 5, 70);
        test_random_traffic(4, 32'($urandom), 200, 65535, 70);
        test_random_traffic(1, 32'h0, 64, 2, 70);

        rx_ch.valid = 1'b0;
        n = 0;
        while (expected_words.size() != 0 && n < STALL_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("words never delivered", expected_words.size(), 0);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/scf_pkg.sv
hdl/scf_in_if.sv
hdl/scf_out_if.sv
hdl/scf_in_reg.sv
hdl/scf_core.sv
hdl/scf_out_reg.sv
hdl/sum_checked_frame_receiver.sv
tb/sv/tb_sum_checked_frame_receiver.sv
